@@ design/idtbl_pkg.sv @@
package idtbl_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int IDX_W           = 9;
    localparam int ID_W            = 32;
    localparam int OP_W            = 2;

    typedef enum logic [OP_W-1:0] {
        OP_FIND  = 2'd0,
        OP_SORT  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_BS_RD,
        ST_BS_CMP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_INSERT,
        ST_SORT_RD,
        ST_SORT_KEY,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PLACE,
        ST_FINISH
    } state_t;

    // read address sources; RD_K reads the entry just below the shift cursor
    typedef enum logic [1:0] {
        RD_MID,
        RD_POS,
        RD_I,
        RD_K
    } rd_sel_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    mid_to_pos;
        logic    bs_step;
        logic    pos_from_lo;
        logic    scan_init;
        logic    scan_next;
        logic    set_hit;
        logic    insert;
        logic    set_full;
        logic    sort_init;
        logic    sort_key;
        logic    shift_wr;
        logic    place;
        logic    clear;
        logic    emit;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic range_empty;
        logic bs_done;
        logic key_eq;
        logic scan_done;
        logic full;
        logic shift_done;
        logic sort_last;
    } status_t;

endpackage

@@ design/idtbl_ctrl.sv @@
module idtbl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    input  idtbl_pkg::status_t st,
    output idtbl_pkg::cmd_t    cmd
);
    import idtbl_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   slot_free;
    logic   is_find;

    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign is_find   = (st.op == OP_FIND);
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (req_valid)
                    state_next = ST_DECODE;
            ST_DECODE:
                unique case (st.op)
                    OP_FIND:  state_next = ST_BS_RD;
                    OP_SORT:  state_next = st.range_empty ? ST_FINISH : ST_SORT_RD;
                    OP_CLEAR: state_next = ST_FINISH;
                    default:  state_next = ST_FINISH;
                endcase
            ST_BS_RD:
                if (!st.bs_done)
                    state_next = ST_BS_CMP;
                else if (is_find)
                    state_next = ST_SCAN_RD;
                else
                    state_next = ST_SHIFT_RD;
            ST_BS_CMP:
                if (!st.key_eq)
                    state_next = ST_BS_RD;
                else if (is_find)
                    state_next = ST_FINISH;
                else
                    state_next = ST_SHIFT_RD;
            ST_SCAN_RD:
                state_next = st.scan_done ? ST_INSERT : ST_SCAN_CMP;
            ST_SCAN_CMP:
                state_next = st.key_eq ? ST_FINISH : ST_SCAN_RD;
            ST_INSERT:
                state_next = ST_FINISH;
            ST_SORT_RD:
                state_next = ST_SORT_KEY;
            ST_SORT_KEY:
                state_next = ST_BS_RD;
            ST_SHIFT_RD:
                state_next = st.shift_done ? ST_PLACE : ST_SHIFT_WR;
            ST_SHIFT_WR:
                state_next = ST_SHIFT_RD;
            ST_PLACE:
                state_next = st.sort_last ? ST_FINISH : ST_SORT_RD;
            ST_FINISH:
                if (slot_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
                cmd.load = req_valid;
            ST_DECODE:
            begin
                cmd.clear     = (st.op == OP_CLEAR);
                cmd.sort_init = (st.op == OP_SORT) && !st.range_empty;
            end
            ST_BS_RD:
                if (!st.bs_done)
                begin
                    cmd.rd_en      = 1'b1;
                    cmd.rd_sel     = RD_MID;
                    cmd.mid_to_pos = 1'b1;
                end
                else if (is_find)
                    cmd.scan_init = 1'b1;
                else
                    cmd.pos_from_lo = 1'b1;
            ST_BS_CMP:
            begin
                cmd.bs_step = !st.key_eq;
                cmd.set_hit = st.key_eq && is_find;
            end
            ST_SCAN_RD:
            begin
                cmd.rd_en  = !st.scan_done;
                cmd.rd_sel = RD_POS;
            end
            ST_SCAN_CMP:
            begin
                cmd.set_hit   = st.key_eq;
                cmd.scan_next = !st.key_eq;
            end
            ST_INSERT:
            begin
                cmd.set_full = st.full;
                cmd.insert   = !st.full;
            end
            ST_SORT_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_I;
            end
            ST_SORT_KEY:
                cmd.sort_key = 1'b1;
            ST_SHIFT_RD:
            begin
                cmd.rd_en  = !st.shift_done;
                cmd.rd_sel = RD_K;
            end
            ST_SHIFT_WR:
                cmd.shift_wr = 1'b1;
            ST_PLACE:
                cmd.place = 1'b1;
            ST_FINISH:
                cmd.emit = slot_free;
            default:
                cmd = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            rsp_valid_next = 1'b1;
        else if (rsp_stall)
            rsp_valid_next = rsp_valid_reg;
        else
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == ST_DECODE))
        else $error("transfer in did not move the controller to decode");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish state");

    a_shift_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT_WR) |-> $past(state_reg == ST_SHIFT_RD))
        else $error("shift write without its read");

endmodule

@@ design/idtbl_dp.sv @@
module idtbl_dp #(
    parameter int TABLE_DEPTH = idtbl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  idtbl_pkg::cmd_t               cmd,
    output idtbl_pkg::status_t            st,
    input  logic [idtbl_pkg::OP_W-1:0]    opcode,
    input  logic [idtbl_pkg::ID_W-1:0]    cell_id,
    input  logic [idtbl_pkg::IDX_W-1:0]   range_low,
    input  logic [idtbl_pkg::IDX_W-1:0]   range_high,
    output logic [idtbl_pkg::IDX_W-1:0]   entry_index,
    output logic                          is_new,
    output logic                          table_full
);
    import idtbl_pkg::*;

    // positions are 1-based and may reach TABLE_DEPTH + 1
    localparam int PW = $clog2(TABLE_DEPTH + 2);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int WW = (PW > IDX_W) ? PW : IDX_W;

    logic [ID_W-1:0] mem [TABLE_DEPTH];

    op_t             op_reg;
    logic [ID_W-1:0] key_reg;
    logic [ID_W-1:0] rd_data_reg;
    logic [PW-1:0]   rlo_reg;
    logic [PW-1:0]   rhi_reg;
    logic            empty_reg;
    logic [PW-1:0]   entry_count_reg;
    logic [PW-1:0]   sorted_count_reg;
    logic [PW-1:0]   lo_reg;
    logic [PW-1:0]   hi_reg;
    logic [PW-1:0]   pos_reg;
    logic [PW-1:0]   i_reg;
    logic [PW-1:0]   k_reg;
    logic [IDX_W-1:0] res_idx_reg;
    logic            res_new_reg;
    logic            res_full_reg;
    logic [IDX_W-1:0] out_idx_reg;
    logic            out_new_reg;
    logic            out_full_reg;

    logic [PW-1:0]   n_head;
    logic [PW:0]     mid_sum;
    logic [PW-1:0]   mid;
    logic [WW-1:0]   rlo_w;
    logic [WW-1:0]   rhi_in_w;
    logic [WW-1:0]   cnt_w;
    logic [WW-1:0]   rhi_w;
    logic [PW-1:0]   rd_entry;
    logic [PW-1:0]   rd_off;
    logic [AW-1:0]   rd_addr;
    logic [PW-1:0]   wr_entry;
    logic [AW-1:0]   wr_addr;
    logic [ID_W-1:0] wr_data;
    logic            wr_en;
    logic            key_lt;

    assign n_head  = (sorted_count_reg < entry_count_reg) ? sorted_count_reg : entry_count_reg;
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[PW:1];
    assign key_lt  = key_reg < rd_data_reg;

    // range bounds: a low bound of zero means the first entry, high clamps to the fill
    assign rlo_w    = (range_low == '0) ? WW'(1) : WW'(range_low);
    assign rhi_in_w = WW'(range_high);
    assign cnt_w    = WW'(entry_count_reg);
    assign rhi_w    = (rhi_in_w > cnt_w) ? cnt_w : rhi_in_w;

    always_comb
    begin
        st.op          = op_reg;
        st.range_empty = empty_reg;
        st.bs_done     = lo_reg > hi_reg;
        st.key_eq      = key_reg == rd_data_reg;
        st.scan_done   = pos_reg > entry_count_reg;
        st.full        = entry_count_reg >= PW'(TABLE_DEPTH);
        st.shift_done  = k_reg <= pos_reg;
        st.sort_last   = i_reg >= rhi_reg;
    end

    always_comb
    begin
        rd_entry = mid;
        rd_off   = PW'(1);
        unique case (cmd.rd_sel)
            RD_MID: rd_entry = mid;
            RD_POS: rd_entry = pos_reg;
            RD_I:   rd_entry = i_reg;
            RD_K:
            begin
                rd_entry = k_reg;
                rd_off   = PW'(2);
            end
            default: rd_entry = mid;
        endcase
    end

    logic [PW-1:0] rd_slot;
    assign rd_slot = rd_entry - rd_off;
    assign rd_addr = rd_slot[AW-1:0];

    always_comb
    begin
        wr_entry = pos_reg;
        wr_data  = key_reg;
        if (cmd.insert)
            wr_entry = entry_count_reg + PW'(1);
        else if (cmd.shift_wr)
        begin
            wr_entry = k_reg;
            wr_data  = rd_data_reg;
        end
    end

    logic [PW-1:0] wr_slot;
    assign wr_slot = wr_entry - PW'(1);
    assign wr_addr = wr_slot[AW-1:0];
    assign wr_en   = cmd.insert || cmd.shift_wr || cmd.place;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= op_t'(opcode);
            key_reg      <= cell_id;
            rlo_reg      <= rlo_w[PW-1:0];
            rhi_reg      <= rhi_w[PW-1:0];
            empty_reg    <= rlo_w > rhi_w;
            lo_reg       <= PW'(1);
            hi_reg       <= n_head;
            res_idx_reg  <= '0;
            res_new_reg  <= 1'b0;
            res_full_reg <= 1'b0;
        end
        if (cmd.mid_to_pos)
            pos_reg <= mid;
        if (cmd.bs_step)
        begin
            if (key_lt)
                hi_reg <= pos_reg - PW'(1);
            else
                lo_reg <= pos_reg + PW'(1);
        end
        if (cmd.pos_from_lo)
            pos_reg <= lo_reg;
        if (cmd.scan_init)
            pos_reg <= n_head + PW'(1);
        if (cmd.scan_next)
            pos_reg <= pos_reg + PW'(1);
        if (cmd.set_hit)
            res_idx_reg <= IDX_W'(pos_reg);
        if (cmd.insert)
        begin
            res_idx_reg <= IDX_W'(entry_count_reg + PW'(1));
            res_new_reg <= 1'b1;
        end
        if (cmd.set_full)
            res_full_reg <= 1'b1;
        if (cmd.sort_init)
            i_reg <= rlo_reg;
        if (cmd.sort_key)
        begin
            key_reg <= rd_data_reg;
            lo_reg  <= PW'(1);
            hi_reg  <= i_reg - PW'(1);
            k_reg   <= i_reg;
        end
        if (cmd.shift_wr)
            k_reg <= k_reg - PW'(1);
        if (cmd.place && !st.sort_last)
            i_reg <= i_reg + PW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg  <= '0;
            sorted_count_reg <= '0;
            out_idx_reg      <= '0;
            out_new_reg      <= 1'b0;
            out_full_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.insert)
                entry_count_reg <= entry_count_reg + PW'(1);
            if (cmd.place && st.sort_last)
                sorted_count_reg <= rhi_reg;
            if (cmd.clear)
            begin
                entry_count_reg  <= '0;
                sorted_count_reg <= '0;
            end
            if (cmd.emit)
            begin
                out_idx_reg  <= res_idx_reg;
                out_new_reg  <= res_new_reg;
                out_full_reg <= res_full_reg;
            end
        end
    end

    assign entry_index = out_idx_reg;
    assign is_new      = out_new_reg;
    assign table_full  = out_full_reg;

    a_sorted_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_count_reg <= entry_count_reg)
        else $error("sorted head longer than the fill");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= PW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_new_or_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_new_reg && out_full_reg))
        else $error("result both new and full");

    a_new_has_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_new_reg |-> (out_idx_reg != '0))
        else $error("new entry reported with index zero");

endmodule

@@ design/id_table_lookup_insert_sort.sv @@
// Identifier table: entries 1..n, sorted head then arrival-order tail, held in a
// single-write, single-read RAM with registered read data. One request at a time;
// each takes one result transfer. Find-or-insert runs a binary search over the
// sorted head, then scans the tail one entry at a time, and on a miss appends the
// identifier unless the table is full. Sort takes each entry in the range in turn,
// finds its place among the entries ahead of it by binary search and shifts the
// entries between up by one, so a large unsorted range is quadratic in the shifts.
// A finished result sits in an output register, so the next request is taken
// while it waits. The input stalls while a request is in progress, including
// while a finished result waits for the output register to free.
module id_table_lookup_insert_sort #(
    parameter int TABLE_DEPTH = idtbl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [idtbl_pkg::OP_W-1:0]    opcode,
    input  logic [idtbl_pkg::ID_W-1:0]    cell_id,
    input  logic [idtbl_pkg::IDX_W-1:0]   range_low,
    input  logic [idtbl_pkg::IDX_W-1:0]   range_high,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [idtbl_pkg::IDX_W-1:0]   entry_index,
    output logic                          is_new,
    output logic                          table_full
);
    import idtbl_pkg::*;

    cmd_t    cmd;
    status_t st;

    idtbl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .st        (st),
        .cmd       (cmd)
    );

    idtbl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .opcode      (opcode),
        .cell_id     (cell_id),
        .range_low   (range_low),
        .range_high  (range_high),
        .entry_index (entry_index),
        .is_new      (is_new),
        .table_full  (table_full)
    );

endmodule

@@ tb/tb_id_table_lookup_insert_sort.sv @@
module tb_id_table_lookup_insert_sort;
    timeunit 1ns;
    timeprecision 1ps;

    import idtbl_pkg::*;

    localparam int     DEPTH          = TABLE_DEPTH_DEF;
    localparam int     CLK_HALF       = 6;
    localparam int     RESET_CYCLES   = 9;
    localparam int     RANDOM_ITEMS   = 1700;
    localparam int     SETTLE_CYCLES  = 64;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     MAX_REPORTS    = 10;
    localparam longint TIMEOUT_CYCLES = 4_000_000;

    // opcode the block decodes as a no-op
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             is_new;
        logic             full;
    } lookup_res_t;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    logic [OP_W-1:0]  opcode;
    logic [ID_W-1:0]  cell_id;
    logic [IDX_W-1:0] range_low;
    logic [IDX_W-1:0] range_high;
    logic             rsp_valid;
    logic             rsp_stall;
    logic [IDX_W-1:0] entry_index;
    logic             is_new;
    logic             table_full;

    // mirror of the table contents, entries 1..n_entries valid
    logic [ID_W-1:0] tbl_ids [1:DEPTH];
    int unsigned     n_entries = 0;
    int unsigned     n_sorted  = 0;

    lookup_res_t pending_results[$];
    int          n_errors     = 0;
    int          items_sent   = 0;
    int          burst_left   = 0;
    int          hold_request = 0;

    id_table_lookup_insert_sort #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .opcode      (opcode),
        .cell_id     (cell_id),
        .range_low   (range_low),
        .range_high  (range_high),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .entry_index (entry_index),
        .is_new      (is_new),
        .table_full  (table_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // binary search over entries 1..n; pos is the hit or the insertion point
    function automatic bit search_ids(input logic [ID_W-1:0] key, input int unsigned n,
                                      output int unsigned pos);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 1;
        hi = (n > DEPTH) ? DEPTH : n;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (key < tbl_ids[mid])
                hi = mid - 1;
            else if (key > tbl_ids[mid])
                lo = mid + 1;
            else
            begin
                pos = mid;
                return 1'b1;
            end
        end
        pos = lo;
        return 1'b0;
    endfunction

    function automatic lookup_res_t update_table_model(input logic [OP_W-1:0] op,
                                                       input logic [ID_W-1:0] id,
                                                       input logic [IDX_W-1:0] lo,
                                                       input logic [IDX_W-1:0] hi);
        lookup_res_t res;
        int unsigned n;
        int unsigned pos;
        int unsigned first;
        int unsigned last;
        logic [ID_W-1:0] moving;
        bit hit;
        res = '0;
        case (op)
            OP_FIND:
            begin
                n   = (n_sorted < n_entries) ? n_sorted : n_entries;
                hit = 1'b0;
                if (n_entries > 0 && search_ids(id, n, pos))
                begin
                    res.idx = IDX_W'(pos);
                    hit     = 1'b1;
                end
                else
                begin
                    for (int unsigned i = n + 1; i <= n_entries && !hit; i++)
                    begin
                        if (tbl_ids[i] == id)
                        begin
                            res.idx = IDX_W'(i);
                            hit     = 1'b1;
                        end
                    end
                end
                if (!hit)
                begin
                    if (n_entries >= DEPTH)
                        res.full = 1'b1;
                    else
                    begin
                        n_entries++;
                        tbl_ids[n_entries] = id;
                        res.idx    = IDX_W'(n_entries);
                        res.is_new = 1'b1;
                    end
                end
            end
            OP_SORT:
            begin
                first = (lo == 0) ? 1 : lo;
                last  = (hi > n_entries) ? n_entries : hi;
                if (first <= last)
                begin
                    for (int unsigned i = first; i <= last; i++)
                    begin
                        moving = tbl_ids[i];
                        void'(search_ids(moving, i - 1, pos));
                        if (pos < i)
                        begin
                            for (int unsigned k = i; k > pos; k--)
                                tbl_ids[k] = tbl_ids[k - 1];
                            tbl_ids[pos] = moving;
                        end
                    end
                    n_sorted = last;
                end
            end
            OP_CLEAR:
            begin
                n_entries = 0;
                n_sorted  = 0;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [IDX_W-1:0] rand_idx();
        return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
    endfunction

    // identifier not yet held in the table
    function automatic logic [ID_W-1:0] fresh_id();
        logic [ID_W-1:0] id;
        bit clash;
        do
        begin
            id    = $urandom;
            clash = 1'b0;
            for (int unsigned i = 1; i <= n_entries; i++)
                if (tbl_ids[i] == id)
                    clash = 1'b1;
        end
        while (clash);
        return id;
    endfunction

    function automatic logic [ID_W-1:0] pick_id(input int flavour);
        case (flavour)
            0: return $urandom;
            1: return $urandom_range(0, 31);
            default:
                case ($urandom_range(4))
                    0: return $urandom_range(0, 3);
                    1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
                    2: return 32'h8000_0000;
                    3: return 32'h7FFF_FFFF;
                    default: return $urandom;
                endcase
        endcase
    endfunction

    // one request transfer; the sender sometimes idles between bursts of random length
    task automatic send_req(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                            input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(9) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
            if ($urandom_range(2) != 0)
            begin
                gap = $urandom_range(1, 8);
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid  <= 1'b1;
        opcode     <= op;
        cell_id    <= id;
        range_low  <= lo;
        range_high <= hi;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        pending_results.push_back(update_table_model(op, id, lo, hi));
        if (op != OP_RESERVED)
            items_sent++;
    endtask

    task automatic find_id(input logic [ID_W-1:0] id);
        send_req(OP_FIND, id, rand_idx(), rand_idx());
    endtask

    task automatic sort_entries(input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi);
        send_req(OP_SORT, $urandom, lo, hi);
    endtask

    task automatic clear_table();
        send_req(OP_CLEAR, $urandom, rand_idx(), rand_idx());
    endtask

    // valid goes low in the step of the last transfer, then wait for all results
    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic test_directed_basics();
        find_id(32'h0000_0000);
        find_id(32'hFFFF_FFFF);
        find_id(32'h0000_0000);              // hit in the tail
        find_id(32'h8000_0000);
        send_req(OP_RESERVED, 32'hFFFF_FFFF, '1, '1);
        sort_entries(9'd0, 9'd511);          // low of 0 counts as 1, high clamped
        find_id(32'hFFFF_FFFF);              // hit by binary search
        find_id(32'h0000_0000);
        find_id(32'h7FFF_FFFF);
        find_id(32'h7FFF_FFFF);
        sort_entries(9'd5, 9'd3);            // empty range
        sort_entries(9'd300, 9'd511);        // starts beyond the last entry
        sort_entries(9'd4, 9'd4);
        find_id(32'h8000_0000);
        clear_table();
        find_id(32'd5);
        find_id(32'd3);
        find_id(32'd9);
        find_id(32'd1);
        sort_entries(9'd3, 9'd4);            // head before the range is not sorted
        find_id(32'd3);
        find_id(32'd1);
        sort_entries(9'd1, 9'd256);
        find_id(32'd9);
        clear_table();
        wait_drained();
    endtask

    task automatic test_table_full();
        clear_table();
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == DEPTH / 2)
                sort_entries(9'd1, IDX_W'(DEPTH / 2));
            find_id(fresh_id());
        end
        find_id(fresh_id());                 // refused, tail unsorted
        find_id(tbl_ids[DEPTH]);
        find_id(tbl_ids[1]);
        sort_entries(9'd0, 9'd256);
        find_id(fresh_id());
        find_id(tbl_ids[DEPTH]);
        find_id(tbl_ids[DEPTH / 2]);
        sort_entries(9'd1, 9'd511);
        send_req(OP_RESERVED, $urandom, rand_idx(), rand_idx());
        clear_table();
        find_id(fresh_id());
        clear_table();
        wait_drained();
    endtask

    // result side held off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        clear_table();
        repeat (4) find_id(pick_id(1));
        hold_request = HOLD_CYCLES;
        repeat (16)
        begin
            if ($urandom_range(1) == 0 && n_entries > 0)
                find_id(tbl_ids[$urandom_range(1, n_entries)]);
            else
                find_id(pick_id(1));
        end
        sort_entries(9'd1, 9'd511);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int target;
        int flavour;
        int sel;
        int unsigned lo;
        int unsigned hi;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            // keep the table small so sorts stay cheap
            if (n_entries > 40 || $urandom_range(3) == 0)
                clear_table();
            flavour = $urandom_range(2);
            repeat (($urandom_range(7) == 0) ? $urandom_range(16, 32) : $urandom_range(1, 12))
                find_id(pick_id(flavour));
            if (n_entries > 0)
            begin
                case ($urandom_range(5))
                    0: sort_entries(9'd1, IDX_W'(n_entries));
                    1:
                    begin
                        lo = $urandom_range(1, n_entries);
                        hi = $urandom_range(lo, n_entries);
                        sort_entries(IDX_W'(lo), IDX_W'(hi));
                    end
                    2: sort_entries(IDX_W'(n_sorted + 1), IDX_W'(n_entries));
                    3: sort_entries(rand_idx(), rand_idx());
                    4: sort_entries(9'd0, 9'd511);
                    default: ;
                endcase
            end
            repeat ($urandom_range(2, 12))
            begin
                sel = $urandom_range(19);
                if (sel < 11 && n_entries > 0)
                    find_id(tbl_ids[$urandom_range(1, n_entries)]);
                else if (sel < 19)
                    find_id(pick_id(flavour));
                else
                    send_req(OP_RESERVED, $urandom, rand_idx(), rand_idx());
            end
        end
        wait_drained();
    endtask

    // result side: the stall rate changes from mode to mode; a long hold on request
    initial
    begin : rsp_side
        int pct;
        int mode_left;
        int n;
        pct       = 0;
        mode_left = 0;
        rsp_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                n            = hold_request;
                hold_request = 0;
                rsp_stall <= 1'b1;
                repeat (n - 1) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(10, 120);
                    case ($urandom_range(3))
                        0: pct = 0;
                        1: pct = 25;
                        2: pct = 50;
                        default: pct = 85;
                    endcase
                end
                mode_left--;
                rsp_stall <= ($urandom_range(99) < pct);
            end
        end
    end

    always @(posedge clk)
    begin : check_rsp
        lookup_res_t want;
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("unexpected result transfer: index %0d new %0b full %0b",
                             entry_index, is_new, table_full);
            end
            else
            begin
                want = pending_results.pop_front();
                if (entry_index !== want.idx || is_new !== want.is_new
                    || table_full !== want.full)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("mismatch: expected index %0d new %0b full %0b,",
                                 want.idx, want.is_new, want.full,
                                 " got index %0d new %0b full %0b",
                                 entry_index, is_new, table_full);
                end
            end
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        opcode     <= OP_FIND;
        cell_id    <= '0;
        range_low  <= '0;
        range_high <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_basics();
        test_table_full();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
design/idtbl_pkg.sv
design/idtbl_ctrl.sv
design/idtbl_dp.sv
design/id_table_lookup_insert_sort.sv
tb/tb_id_table_lookup_insert_sort.sv
